@@ sv/double_ended_queue_top_defines.svh @@
// Assertion macros shared by the checker of the double-ended queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dq_pkg.sv @@
// Package of the double-ended queue: field widths, function and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package dq_pkg;

    // Widths of the channel fields.
    localparam int FUNC_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 6;
    localparam int TGT_W     = 7;
    localparam int RDATA_W   = 32;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W  = 2;

    // Function codes of a request word.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RESIZE     = 3'd6;

    // Status codes of a response word.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;       // a request word is accepted this cycle
        logic fill_step;  // append one fill entry at the back
        logic load_out;   // move the finished result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fill;  // the accepted resize must append entries
        logic fill_last;  // this fill step reaches the wanted count
    } dp_status_t;

endpackage

@@ sv/dq_in_if.sv @@
// Request channel of the double-ended queue: valid, ready and the request word.
// Depends on dq_pkg.
interface dq_in_if;
    logic                         valid;
    logic                         ready;
    logic [dq_pkg::FUNC_W-1:0]    func;
    logic [dq_pkg::VALUE_W-1:0]   value;
    logic [dq_pkg::POS_W-1:0]     position;
    logic [dq_pkg::TGT_W-1:0]     target_count;

    modport source (output valid, func, value, position, target_count, input ready);
    modport sink   (input valid, func, value, position, target_count, output ready);
endinterface

@@ sv/dq_out_if.sv @@
// Response channel of the double-ended queue: valid, ready and the response word.
// Depends on dq_pkg.
interface dq_out_if;
    logic                          valid;
    logic                          ready;
    logic [dq_pkg::RDATA_W-1:0]    read_data;
    logic [dq_pkg::CNT_OUT_W-1:0]  count_now;
    logic [dq_pkg::STATUS_W-1:0]   status;
    logic                          is_empty;

    modport source (output valid, read_data, count_now, status, is_empty, input ready);
    modport sink   (input valid, read_data, count_now, status, is_empty, output ready);
endinterface

@@ sv/double_ended_queue_top.sv @@
// Top level of the double-ended queue: controller plus datapath on two channels.
// Depends on dq_pkg, dq_in_if, dq_out_if, dq_ctrl and dq_datapath.
//
//   Channel  Dir  Word fields
//   req      in   func, value, position, target_count
//   rsp      out  read_data, count_now, status, is_empty
//
// Push, pop, read, clear and a shrinking resize first execute (and start the registered
// RAM read), then load the output register.
// A growing resize adds a fill step for each appended entry, bound by the single RAM write port.
// Reset clears the count and front pointer at once; the entry RAM needs no clearing pass.
// A new request is taken while an older response waits in the output register;
// a finished result then holds in the controller until that register is free.
module double_ended_queue_top #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    dq_in_if.sink           req,
    dq_out_if.source        rsp
);

    dq_pkg::ctrl_cmd_t  cmd;
    dq_pkg::dp_status_t stat;

    // Sequencing of each request.
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Queue state and storage.
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (req.func),
        .value        (req.value),
        .position     (req.position),
        .target_count (req.target_count),
        .read_data    (rsp.read_data),
        .count_now    (rsp.count_now),
        .status       (rsp.status),
        .is_empty     (rsp.is_empty)
    );

endmodule

@@ sv/dq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/dq_ctrl.sv @@
// Controller of the double-ended queue: sequences accept, fill and result hand-off.
// Depends on dq_pkg.
module dq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dq_pkg::dp_status_t stat,
    output dq_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FILL = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.exec      = 1'b0;
        cmd.fill_step = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.need_fill ? S_FILL : S_DONE;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register is full from a load until the word is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/dq_datapath.sv @@
// Datapath of the double-ended queue: front pointer, count, entry RAM and
// output register. Depends on dq_pkg and dq_ram.
module dq_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dq_pkg::ctrl_cmd_t              cmd,
    output dq_pkg::dp_status_t             stat,
    input  logic [dq_pkg::FUNC_W-1:0]      func,
    input  logic [dq_pkg::VALUE_W-1:0]     value,
    input  logic [dq_pkg::POS_W-1:0]       position,
    input  logic [dq_pkg::TGT_W-1:0]       target_count,
    output logic [dq_pkg::RDATA_W-1:0]     read_data,
    output logic [dq_pkg::CNT_OUT_W-1:0]   count_now,
    output logic [dq_pkg::STATUS_W-1:0]    status,
    output logic                           is_empty
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > dq_pkg::TGT_W) ? CNT_W : dq_pkg::TGT_W;
    localparam int SUM_W  = CMP_W + 1;
    localparam int DW_EXT = (DATA_WIDTH > dq_pkg::VALUE_W) ? DATA_WIDTH : dq_pkg::VALUE_W;

    logic [PTR_W-1:0]               front_reg, front_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               fill_target_reg, fill_target_next;
    logic [DATA_WIDTH-1:0]          fill_value_reg, fill_value_next;
    logic [dq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                           rd_ok_reg, rd_ok_next;
    logic [dq_pkg::RDATA_W-1:0]     out_data_reg;
    logic [dq_pkg::CNT_OUT_W-1:0]   out_count_reg;
    logic [dq_pkg::STATUS_W-1:0]    out_status_reg;
    logic                           out_empty_reg;

    logic                           ram_we, ram_re;
    logic [PTR_W-1:0]               ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]          ram_wdata, ram_q;

    logic [DW_EXT-1:0]              value_ext, q_ext;
    logic [DATA_WIDTH-1:0]          value_dw;
    logic [SUM_W-1:0]               back_sum, back_wrap, read_sum, read_wrap;
    logic [PTR_W-1:0]               back_addr, read_addr, front_dec, front_inc;
    logic [CMP_W-1:0]               count_cmp, pos_cmp, tgt_cmp, depth_cmp, tgt_eff_cmp;
    logic [CNT_W-1:0]               tgt_eff;
    logic                           tgt_sat, is_full, is_zero, is_one;

    // Fit the request value to the stored word width.
    assign value_ext = DW_EXT'(value);
    assign value_dw  = value_ext[DATA_WIDTH-1:0];

    // Circular addresses of the slot past the back and of the read position.
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;
    assign back_addr = back_wrap[PTR_W-1:0];
    assign read_sum  = SUM_W'(front_reg) + SUM_W'(position);
    assign read_wrap = (read_sum >= SUM_W'(DEPTH)) ? read_sum - SUM_W'(DEPTH) : read_sum;
    assign read_addr = read_wrap[PTR_W-1:0];

    // Front pointer moved one slot either way.
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // Count checks and the resize target clamped to the depth.
    assign count_cmp   = CMP_W'(count_reg);
    assign pos_cmp     = CMP_W'(position);
    assign tgt_cmp     = CMP_W'(target_count);
    assign depth_cmp   = CMP_W'(DEPTH);
    assign tgt_sat     = (tgt_cmp > depth_cmp);
    assign tgt_eff_cmp = tgt_sat ? depth_cmp : tgt_cmp;
    assign tgt_eff     = tgt_eff_cmp[CNT_W-1:0];
    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign is_zero     = (count_reg == '0);
    assign is_one      = (count_reg == CNT_W'(1));

    // Status toward the controller.
    assign stat.need_fill = (func == dq_pkg::FUNC_RESIZE) && (count_cmp < tgt_eff_cmp);
    assign stat.fill_last = ((count_reg + 1'b1) == fill_target_reg);

    // Execution of an accepted request word and of fill steps.
    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        fill_target_next = fill_target_reg;
        fill_value_next  = fill_value_reg;
        status_next      = status_reg;
        rd_ok_next       = rd_ok_reg;
        ram_we           = 1'b0;
        ram_waddr        = back_addr;
        ram_wdata        = value_dw;
        ram_re           = 1'b0;
        ram_raddr        = read_addr;
        if (cmd.fill_step)
        begin
            ram_we     = 1'b1;
            ram_wdata  = fill_value_reg;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.exec)
        begin
            status_next = dq_pkg::ST_OK;
            rd_ok_next  = 1'b0;
            unique case (func)
                dq_pkg::FUNC_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::FUNC_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_next = is_zero ? '0 : front_dec;
                        ram_we     = 1'b1;
                        ram_waddr  = front_next;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::FUNC_POP_BACK:
                begin
                    if (is_zero)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (is_one)
                        begin
                            front_next = '0;
                        end
                    end
                end
                dq_pkg::FUNC_POP_FRONT:
                begin
                    if (is_zero)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        front_next = is_one ? '0 : front_inc;
                    end
                end
                dq_pkg::FUNC_READ:
                begin
                    if (pos_cmp >= count_cmp)
                    begin
                        status_next = dq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        rd_ok_next = 1'b1;
                    end
                end
                dq_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                    front_next = '0;
                end
                dq_pkg::FUNC_RESIZE:
                begin
                    if (tgt_sat)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    if (stat.need_fill)
                    begin
                        fill_target_next = tgt_eff;
                        fill_value_next  = value_dw;
                    end
                    else
                    begin
                        count_next = tgt_eff;
                        if (tgt_eff == '0)
                        begin
                            front_next = '0;
                        end
                    end
                end
                default:
                begin
                    status_next = dq_pkg::ST_OK;
                end
            endcase
        end
    end

    // Pointer and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Per-request payload held until the result is handed off.
    always_ff @(posedge clk)
    begin
        fill_target_reg <= fill_target_next;
        fill_value_reg  <= fill_value_next;
        status_reg      <= status_next;
        rd_ok_reg       <= rd_ok_next;
    end

    // Output register.
    assign q_ext = DW_EXT'(ram_q);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg   <= rd_ok_reg ? q_ext[dq_pkg::RDATA_W-1:0] : '0;
            out_count_reg  <= count_cmp[dq_pkg::CNT_OUT_W-1:0];
            out_status_reg <= status_reg;
            out_empty_reg  <= is_zero;
        end
    end

    assign read_data = out_data_reg;
    assign count_now = out_count_reg;
    assign status    = out_status_reg;
    assign is_empty  = out_empty_reg;

    // Entry store.
    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

endmodule

@@ sv/dq_checker.sv @@
// Port-level checker of the double-ended queue and its bind to the top level.
// Depends on dq_pkg and double_ended_queue_top_defines.svh.
`include "double_ended_queue_top_defines.svh"

module dq_checker #(
    parameter int DEPTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [dq_pkg::RDATA_W-1:0]    rsp_read_data,
    input logic [dq_pkg::CNT_OUT_W-1:0]  rsp_count_now,
    input logic [dq_pkg::STATUS_W-1:0]   rsp_status,
    input logic                          rsp_is_empty
);

    // The count field shows the whole count only when the depth fits in it.
    localparam bit CNT_EXACT = (DEPTH < (1 << dq_pkg::CNT_OUT_W));

    // A stalled response word holds.
    `DQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_count_now) && $stable(rsp_status) && $stable(rsp_is_empty), "response word changed while stalled")

    // A failed operation returns no data.
    `DQ_ASSERT_NOW(a_err_no_data, rsp_valid && (rsp_status != dq_pkg::ST_OK), rsp_read_data == '0, "read data on a failed operation")

    // A pop on an empty queue leaves it empty.
    `DQ_ASSERT_NOW(a_empty_flag, rsp_valid && (rsp_status == dq_pkg::ST_EMPTY), rsp_is_empty, "empty status with entries held")

    // A full or saturated operation leaves the queue holding entries.
    `DQ_ASSERT_NOW(a_full_flag, rsp_valid && (rsp_status == dq_pkg::ST_FULL), !rsp_is_empty, "full status on an empty queue")

    // The empty flag agrees with the count.
    `DQ_ASSERT_NOW(a_empty_count, rsp_valid && CNT_EXACT, rsp_is_empty == (rsp_count_now == '0), "empty flag disagrees with count")

endmodule

bind double_ended_queue_top dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_count_now (rsp.count_now),
    .rsp_status    (rsp.status),
    .rsp_is_empty  (rsp.is_empty)
);
